// File: rtl/swhsr_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader package
// Shared types and constants for the sensor reader core and its top level.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int TICK_BITS = 16;
  localparam int CMP_BITS  = (TICK_BITS > 16) ? TICK_BITS : 16;

  localparam int FRAME_BITS    = 40;
  localparam int SKIP_EDGES    = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [7:0]  BIT_THRESHOLD_RST = 8'd100;
  localparam logic [15:0] START_TICKS_RST   = 16'd2000;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd256;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_START   = 2'd1,
    PH_MEASURE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BIT_THRESHOLD = 2'd0,
    CFG_START_TICKS   = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  bit_threshold;
    logic [15:0] start_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy;
    logic               done;
    status_e            status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
  } result_t;

endpackage

// File: rtl/swhsr_core.sv
// ----------------------------------------------------------------------------
// Sensor reader core
// Holds the read sequencer state and turns one line sample into one result.
// ----------------------------------------------------------------------------
module swhsr_core
  import swhsr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    line_level_i,
  input  logic    start_request_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  phase_e                 phase_q, phase_d;
  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic                   last_level_q;
  logic [1:0]             skipped_q, skipped_d;
  logic [5:0]             bits_q, bits_d;
  logic [FRAME_BITS-1:0]  frame_q, frame_d;
  logic [15:0]            humidity_q, humidity_d;
  logic [15:0]            temperature_q, temperature_d;

  logic                   done;
  status_e                status;
  logic [TICK_BITS-1:0]   tick_inc;
  logic                   tick_sat;
  logic [7:0]             sum;
  logic [14:0]            mag;

  assign tick_sat = (tick_inc == {TICK_BITS{1'b1}});

  always_comb begin
    tick_inc = (tick_q == {TICK_BITS{1'b1}}) ? tick_q : tick_q + 1'b1;
  end

  // Next-state logic of the read sequencer and the frame datapath.
  always_comb begin
    phase_d       = phase_q;
    tick_d        = tick_q;
    skipped_d     = skipped_q;
    bits_d        = bits_q;
    frame_d       = frame_q;
    humidity_d    = humidity_q;
    temperature_d = temperature_q;
    done          = 1'b0;
    status        = ST_OK;
    sum           = '0;
    mag           = '0;
    unique case (phase_q)
      PH_START: begin
        tick_d = tick_inc;
        if (CMP_BITS'(tick_inc) >= CMP_BITS'(cfg_i.start_ticks) || tick_sat) begin
          phase_d = PH_MEASURE;
          tick_d  = '0;
        end
      end
      PH_MEASURE: begin
        tick_d = tick_inc;
        if (line_level_i != last_level_q) begin
          tick_d = '0;
          if (!line_level_i) begin
            if (skipped_q < 2'(SKIP_EDGES)) begin
              skipped_d = skipped_q + 1'b1;
            end else begin
              // A pulse longer than the threshold is a one.
              frame_d = {frame_q[FRAME_BITS-2:0],
                         (CMP_BITS'(tick_inc) > CMP_BITS'(cfg_i.bit_threshold))};
              bits_d  = bits_q + 1'b1;
              if (bits_q >= 6'(FRAME_BITS - 1)) begin
                done    = 1'b1;
                phase_d = PH_IDLE;
                sum = frame_d[39:32] + frame_d[31:24] + frame_d[23:16] + frame_d[15:8];
                if (sum != frame_d[7:0]) begin
                  status = ST_CHECKSUM;
                end else begin
                  humidity_d = frame_d[39:24];
                  mag        = frame_d[22:8];
                  temperature_d = frame_d[23] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
                end
              end
            end
          end
        end else if (CMP_BITS'(tick_inc) >= CMP_BITS'(cfg_i.timeout_ticks) || tick_sat) begin
          done    = 1'b1;
          status  = ST_TIMEOUT;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // Idle waits here for a start request; the unused phase code falls back to idle.
        phase_d = PH_IDLE;
        if (start_request_i) begin
          phase_d   = PH_START;
          tick_d    = '0;
          skipped_d = '0;
          bits_d    = '0;
          frame_d   = '0;
        end
      end
    endcase
  end

  // Result word, showing the state after this sample.
  always_comb begin
    result_o.drive_low   = (phase_d == PH_START);
    result_o.busy        = (phase_d != PH_IDLE);
    result_o.done        = done;
    result_o.status      = status;
    result_o.humidity    = humidity_d;
    result_o.temperature = temperature_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tick_q        <= '0;
      last_level_q  <= 1'b1;
      skipped_q     <= '0;
      bits_q        <= '0;
      frame_q       <= '0;
      humidity_q    <= '0;
      temperature_q <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      tick_q        <= tick_d;
      last_level_q  <= line_level_i;
      skipped_q     <= skipped_d;
      bits_q        <= bits_d;
      frame_q       <= frame_d;
      humidity_q    <= humidity_d;
      temperature_q <= temperature_d;
    end
  end

endmodule

// File: rtl/single_wire_humidity_sensor_reader_top.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader
// The result of a sample is registered in the output register, or in the skid word while the output is held.
// Throughput: one sample per cycle while in_ready_o is high; the core state updates in a single pass.
// A two-entry output stage keeps samples flowing while a result waits.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle,
// clears the held readings and loads the default register values.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_top
  import swhsr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     line_level_i,
  input  logic                     start_request_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     drive_low_o,
  output logic                     busy_res_o,
  output logic                     done_res_o,
  output logic [1:0]               status_o,
  output logic [15:0]              humidity_o,
  output logic signed [15:0]       temperature_o
);

  cfg_t    cfg_q;
  result_t result;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    in_fire;
  logic    out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold <= BIT_THRESHOLD_RST;
      cfg_q.start_ticks   <= START_TICKS_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BIT_THRESHOLD: cfg_q.bit_threshold <= cfg_data_i[7:0];
        CFG_START_TICKS:   cfg_q.start_ticks   <= cfg_data_i;
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  swhsr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_fire),
    .line_level_i    (line_level_i),
    .start_request_i (start_request_i),
    .cfg_i           (cfg_q),
    .result_o        (result)
  );

  // Output register with a skid word behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_low_o   = out_q.drive_low;
  assign busy_res_o    = out_q.busy;
  assign done_res_o    = out_q.done;
  assign status_o      = out_q.status;
  assign humidity_o    = out_q.humidity;
  assign temperature_o = out_q.temperature;

endmodule
